// ----- hdl/rc_channel_normalizer_defines.svh -----
// Assertion macros for the radio-control channel normalizer.
`ifndef RC_CHANNEL_NORMALIZER_DEFINES_SVH
`define RC_CHANNEL_NORMALIZER_DEFINES_SVH

// cond_a in a cycle requires cond_b in the same cycle
`define RCN_ASSERT_IMPLIES(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("rcn implication check failed");

// cond must never hold
`define RCN_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rcn forbidden condition seen");

`endif

// ----- hdl/rcn_pkg.sv -----
// Shared constants and types for the radio-control channel normalizer.
package rcn_pkg;

  localparam int PULSE_BITS_DEFAULT = 12;
  localparam int DB_BITS = 10;
  localparam int TH_BITS = 16;
  localparam int POL_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int QUO_BITS = 16;
  localparam int FRAC_BITS = 15;
  localparam int Q_BITS = 16;
  localparam int SW_POS_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_PULSE      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PULSE      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_PULSE   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEADBAND       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FAILSAFE_PULSE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ON_THRESHOLD   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MID_THRESHOLD  = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POLARITY_FLAGS = 3'd7;

  localparam int RST_MIN_PULSE = 1000;
  localparam int RST_MAX_PULSE = 2000;
  localparam int RST_CENTER_PULSE = 1500;
  localparam logic [DB_BITS-1:0] RST_DEADBAND = '0;
  localparam int RST_FAILSAFE_PULSE = 0;
  localparam logic [TH_BITS-1:0] RST_ON_THRESHOLD = 16'd24576;
  localparam logic [TH_BITS-1:0] RST_MID_THRESHOLD = 16'd8192;
  localparam logic [POL_BITS-1:0] RST_POLARITY = '0;

  localparam int POL_REVERSE = 0;
  localparam int POL_INV_ON = 1;
  localparam int POL_INV_MID = 2;

  localparam logic signed [Q_BITS-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [Q_BITS-1:0] Q_MIN = 16'sh8000;

  localparam logic [SW_POS_BITS-1:0] SW_OFF = 2'd0;
  localparam logic [SW_POS_BITS-1:0] SW_MID = 2'd1;
  localparam logic [SW_POS_BITS-1:0] SW_ON  = 2'd2;

  typedef struct packed {
    logic neg;
    logic big;
    logic trip;
  } flags_t;

endpackage

// ----- hdl/rcn_front.sv -----
// Front stages: clamp, failsafe check, dead-zone branch, divisor select and overflow check.
module rcn_front #(
  parameter int PULSE_BITS = rcn_pkg::PULSE_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [PULSE_BITS-1:0]                  raw_pulse,
  input  logic [PULSE_BITS-1:0]                  min_pulse,
  input  logic [PULSE_BITS-1:0]                  max_pulse,
  input  logic [PULSE_BITS-1:0]                  center_pulse,
  input  logic [rcn_pkg::DB_BITS-1:0]            deadband,
  input  logic [PULSE_BITS-1:0]                  failsafe_pulse,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [PULSE_BITS+rcn_pkg::FRAC_BITS:0] rem,
  output logic [PULSE_BITS-1:0]                  den,
  output rcn_pkg::flags_t                        flags
);

  localparam int SW = PULSE_BITS + 12;

  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready;

  logic [PULSE_BITS-1:0] a_v;
  logic                  a_trip;
  logic [PULSE_BITS-1:0] b_mag;
  logic [PULSE_BITS-1:0] b_den;
  logic                  b_neg;
  logic                  b_trip;

  logic [PULSE_BITS-1:0] v_lo, v_next;
  logic                  trip_next;

  logic signed [SW-1:0] v_s, c_s, d_s, mn_s, mx_s, hi, lo;
  logic signed [SW-1:0] up_num, dn_num, up_den, dn_den, sel_num, sel_den;
  logic                 up, dn, ok;

  assign c_ready = !c_valid || out_ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign v_lo = (raw_pulse < min_pulse) ? min_pulse : raw_pulse;
  assign v_next = (v_lo > max_pulse) ? max_pulse : v_lo;
  assign trip_next = (failsafe_pulse != '0) &&
                     (((failsafe_pulse < min_pulse) && (raw_pulse < failsafe_pulse)) ||
                      ((failsafe_pulse > max_pulse) && (raw_pulse > failsafe_pulse)));

  assign v_s  = $signed({{(SW-PULSE_BITS){1'b0}}, a_v});
  assign c_s  = $signed({{(SW-PULSE_BITS){1'b0}}, center_pulse});
  assign mn_s = $signed({{(SW-PULSE_BITS){1'b0}}, min_pulse});
  assign mx_s = $signed({{(SW-PULSE_BITS){1'b0}}, max_pulse});
  assign d_s  = $signed({{(SW-rcn_pkg::DB_BITS){1'b0}}, deadband});
  assign hi = c_s + d_s;
  assign lo = c_s - d_s;
  assign up_num = v_s - hi;
  assign dn_num = lo - v_s;
  assign up_den = mx_s - hi;
  assign dn_den = lo - mn_s;
  assign up = up_num > SW'(0);
  assign dn = dn_num > SW'(0);
  assign sel_num = up ? up_num : dn_num;
  assign sel_den = up ? up_den : dn_den;
  assign ok = (up || dn) && (sel_den > SW'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_v <= v_next;
      a_trip <= trip_next;
    end
    if (b_ready && a_valid) begin
      b_mag <= ok ? sel_num[PULSE_BITS-1:0] : '0;
      b_den <= ok ? sel_den[PULSE_BITS-1:0] : PULSE_BITS'(1);
      b_neg <= dn;
      b_trip <= a_trip;
    end
    if (c_ready && b_valid) begin
      rem <= {1'b0, b_mag, {rcn_pkg::FRAC_BITS{1'b0}}};
      den <= b_den;
      flags.neg <= b_neg;
      flags.big <= {1'b0, b_mag} >= {b_den, 1'b0};
      flags.trip <= b_trip;
    end
  end

  assign out_valid = c_valid;

endmodule

// ----- hdl/rcn_div_stage.sv -----
// One restoring-division stage: resolves a single quotient bit.
module rcn_div_stage #(
  parameter int PULSE_BITS = rcn_pkg::PULSE_BITS_DEFAULT,
  parameter int SHIFT = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [PULSE_BITS+rcn_pkg::FRAC_BITS:0] rem_in,
  input  logic [PULSE_BITS-1:0]                  den_in,
  input  logic [rcn_pkg::QUO_BITS-1:0]           quo_in,
  input  rcn_pkg::flags_t                        flags_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [PULSE_BITS+rcn_pkg::FRAC_BITS:0] rem_out,
  output logic [PULSE_BITS-1:0]                  den_out,
  output logic [rcn_pkg::QUO_BITS-1:0]           quo_out,
  output rcn_pkg::flags_t                        flags_out
);

  localparam int RW = PULSE_BITS + rcn_pkg::FRAC_BITS + 1;

  logic [RW-1:0]                 den_sh;
  logic                          ge;
  logic [rcn_pkg::QUO_BITS-1:0]  quo_next;

  assign den_sh = {{(RW-PULSE_BITS){1'b0}}, den_in} << SHIFT;
  assign ge = rem_in >= den_sh;

  always_comb begin
    quo_next = quo_in;
    quo_next[SHIFT] = ge;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_out <= ge ? (rem_in - den_sh) : rem_in;
      den_out <= den_in;
      quo_out <= quo_next;
      flags_out <= flags_in;
    end
  end

endmodule

// ----- hdl/rcn_back.sv -----
// Back stages: sign, reversal, Q1.15 saturation and switch decode.
module rcn_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rcn_pkg::QUO_BITS-1:0]        quo,
  input  rcn_pkg::flags_t                     flags,
  input  logic [rcn_pkg::TH_BITS-1:0]         on_threshold,
  input  logic [rcn_pkg::TH_BITS-1:0]         mid_threshold,
  input  logic [rcn_pkg::POL_BITS-1:0]        polarity_flags,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rcn_pkg::Q_BITS-1:0]   normalized,
  output logic [rcn_pkg::SW_POS_BITS-1:0]     switch_position,
  output logic                                failsafe_trip
);

  logic s_valid, s_ready, o_ready;
  logic signed [rcn_pkg::Q_BITS-1:0] s_q;
  logic s_trip;

  logic neg, sat;
  logic signed [rcn_pkg::Q_BITS-1:0] q_next;
  logic [rcn_pkg::Q_BITS:0] s_ext, t_on, t_mid;
  logic on_hit, mid_hit;
  logic [rcn_pkg::SW_POS_BITS-1:0] pos_next;

  assign neg = flags.neg ^ polarity_flags[rcn_pkg::POL_REVERSE];
  assign sat = flags.big || quo[rcn_pkg::QUO_BITS-1];

  always_comb begin
    if (sat) begin
      q_next = neg ? rcn_pkg::Q_MIN : rcn_pkg::Q_MAX;
    end else if (neg) begin
      q_next = $signed(rcn_pkg::Q_BITS'(~quo + 1'b1));
    end else begin
      q_next = $signed(quo);
    end
  end

  assign s_ext = {1'b0, ~s_q[rcn_pkg::Q_BITS-1], s_q[rcn_pkg::Q_BITS-2:0]};
  assign t_on = {on_threshold, 1'b0};
  assign t_mid = {mid_threshold, 1'b0};
  assign on_hit = polarity_flags[rcn_pkg::POL_INV_ON] ? (s_ext < t_on) : (s_ext > t_on);
  assign mid_hit = polarity_flags[rcn_pkg::POL_INV_MID] ? (s_ext < t_mid) : (s_ext > t_mid);

  always_comb begin
    if (on_hit) begin
      pos_next = rcn_pkg::SW_ON;
    end else if (mid_hit) begin
      pos_next = rcn_pkg::SW_MID;
    end else begin
      pos_next = rcn_pkg::SW_OFF;
    end
  end

  assign o_ready = !out_valid || out_ready;
  assign s_ready = !s_valid || o_ready;
  assign in_ready = s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_ready) s_valid <= in_valid;
      if (o_ready) out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && in_valid) begin
      s_q <= q_next;
      s_trip <= flags.trip;
    end
    if (o_ready && s_valid) begin
      normalized <= s_q;
      switch_position <= pos_next;
      failsafe_trip <= s_trip;
    end
  end

endmodule

// ----- hdl/rc_channel_normalizer.sv -----
// Top level of the radio-control channel normalizer: registers and pipeline.
//
//   channel  signals                                     direction
//   pulse    pulse_valid, pulse_stall, raw_pulse         in
//   result   result_valid, result_stall, normalized,
//            switch_position, failsafe_trip              out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data   in
//
// One item per cycle while result_stall is low; 3 front stages, 16 divider stages
// (one quotient bit each), 2 back stages.
// Reset clears every stage valid bit and loads the register defaults.
// A stage holds while its successor is full and held; empty stages fill up,
// so pulse_stall rises only once the whole pipeline is full and result is held.
// cfg_ready is always high.
`include "rc_channel_normalizer_defines.svh"

module rc_channel_normalizer #(
  parameter int PULSE_BITS = rcn_pkg::PULSE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pulse_valid,
  output logic                                  pulse_stall,
  input  logic [PULSE_BITS-1:0]                 raw_pulse,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [rcn_pkg::Q_BITS-1:0]     normalized,
  output logic [rcn_pkg::SW_POS_BITS-1:0]       switch_position,
  output logic                                  failsafe_trip,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rcn_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [rcn_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int RW = PULSE_BITS + rcn_pkg::FRAC_BITS + 1;
  localparam int NQ = rcn_pkg::QUO_BITS;

  logic [PULSE_BITS-1:0]           min_pulse;
  logic [PULSE_BITS-1:0]           max_pulse;
  logic [PULSE_BITS-1:0]           center_pulse;
  logic [rcn_pkg::DB_BITS-1:0]     deadband;
  logic [PULSE_BITS-1:0]           failsafe_pulse;
  logic [rcn_pkg::TH_BITS-1:0]     on_threshold;
  logic [rcn_pkg::TH_BITS-1:0]     mid_threshold;
  logic [rcn_pkg::POL_BITS-1:0]    polarity_flags;

  logic                            front_ready;
  logic                            back_ready;
  logic                            vld_c   [NQ+1];
  logic                            rdy_c   [NQ+1];
  logic [RW-1:0]                   rem_c   [NQ+1];
  logic [PULSE_BITS-1:0]           den_c   [NQ+1];
  logic [NQ-1:0]                   quo_c   [NQ+1];
  rcn_pkg::flags_t                 flags_c [NQ+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse <= PULSE_BITS'(rcn_pkg::RST_MIN_PULSE);
      max_pulse <= PULSE_BITS'(rcn_pkg::RST_MAX_PULSE);
      center_pulse <= PULSE_BITS'(rcn_pkg::RST_CENTER_PULSE);
      deadband <= rcn_pkg::RST_DEADBAND;
      failsafe_pulse <= PULSE_BITS'(rcn_pkg::RST_FAILSAFE_PULSE);
      on_threshold <= rcn_pkg::RST_ON_THRESHOLD;
      mid_threshold <= rcn_pkg::RST_MID_THRESHOLD;
      polarity_flags <= rcn_pkg::RST_POLARITY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcn_pkg::CFG_MIN_PULSE: begin
          min_pulse <= cfg_data[PULSE_BITS-1:0];
        end
        rcn_pkg::CFG_MAX_PULSE: begin
          max_pulse <= cfg_data[PULSE_BITS-1:0];
        end
        rcn_pkg::CFG_CENTER_PULSE: begin
          center_pulse <= cfg_data[PULSE_BITS-1:0];
        end
        rcn_pkg::CFG_DEADBAND: begin
          deadband <= cfg_data[rcn_pkg::DB_BITS-1:0];
        end
        rcn_pkg::CFG_FAILSAFE_PULSE: begin
          failsafe_pulse <= cfg_data[PULSE_BITS-1:0];
        end
        rcn_pkg::CFG_ON_THRESHOLD: begin
          on_threshold <= cfg_data[rcn_pkg::TH_BITS-1:0];
        end
        rcn_pkg::CFG_MID_THRESHOLD: begin
          mid_threshold <= cfg_data[rcn_pkg::TH_BITS-1:0];
        end
        rcn_pkg::CFG_POLARITY_FLAGS: begin
          polarity_flags <= cfg_data[rcn_pkg::POL_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign pulse_stall = !front_ready;

  rcn_front #(
    .PULSE_BITS(PULSE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (pulse_valid),
    .in_ready       (front_ready),
    .raw_pulse      (raw_pulse),
    .min_pulse      (min_pulse),
    .max_pulse      (max_pulse),
    .center_pulse   (center_pulse),
    .deadband       (deadband),
    .failsafe_pulse (failsafe_pulse),
    .out_valid      (vld_c[0]),
    .out_ready      (rdy_c[0]),
    .rem            (rem_c[0]),
    .den            (den_c[0]),
    .flags          (flags_c[0])
  );

  assign quo_c[0] = '0;

  for (genvar i = 0; i < NQ; i++) begin : g_div
    rcn_div_stage #(
      .PULSE_BITS(PULSE_BITS),
      .SHIFT(NQ - 1 - i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld_c[i]),
      .in_ready  (rdy_c[i]),
      .rem_in    (rem_c[i]),
      .den_in    (den_c[i]),
      .quo_in    (quo_c[i]),
      .flags_in  (flags_c[i]),
      .out_valid (vld_c[i+1]),
      .out_ready (rdy_c[i+1]),
      .rem_out   (rem_c[i+1]),
      .den_out   (den_c[i+1]),
      .quo_out   (quo_c[i+1]),
      .flags_out (flags_c[i+1])
    );
  end

  assign rdy_c[NQ] = back_ready;

  rcn_back u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (vld_c[NQ]),
    .in_ready        (back_ready),
    .quo             (quo_c[NQ]),
    .flags           (flags_c[NQ]),
    .on_threshold    (on_threshold),
    .mid_threshold   (mid_threshold),
    .polarity_flags  (polarity_flags),
    .out_valid       (result_valid),
    .out_ready       (!result_stall),
    .normalized      (normalized),
    .switch_position (switch_position),
    .failsafe_trip   (failsafe_trip)
  );

  `RCN_ASSERT_IMPLIES(a_empty_takes_item, !result_valid, !pulse_stall)
  `RCN_ASSERT_IMPLIES(a_no_trip_when_off, result_valid && (failsafe_pulse == '0), !failsafe_trip)
  `RCN_ASSERT_NEVER(a_switch_code, result_valid && (switch_position == 2'd3))

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the radio-control channel normalizer.
module testbench;

  localparam int LATENCY_CYCLES = 21;
  localparam int LONG_HOLD = 300;
  localparam int RUN_LIMIT = 200000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 48;

  typedef struct packed {
    logic signed [rcn_pkg::Q_BITS-1:0] normalized;
    logic [rcn_pkg::SW_POS_BITS-1:0]   switch_position;
    logic                              failsafe_trip;
  } chan_result_t;

  typedef struct packed {
    logic [11:0]  raw;
    logic         typed;
    chan_result_t res;
  } reset_row_t;

  typedef struct packed {
    logic [11:0] mn;
    logic [11:0] mx;
    logic [11:0] ctr;
    logic [9:0]  db;
    logic [11:0] fs;
    logic [15:0] onth;
    logic [15:0] midth;
    logic [2:0]  pl;
    logic [11:0] p0;
    logic [11:0] p1;
    logic [11:0] p2;
  } corner_setting_t;

  localparam reset_row_t RESET_ROWS [9] = '{
    '{12'd1500, 1'b1, '{16'sd0, rcn_pkg::SW_MID, 1'b0}},
    '{12'd2000, 1'b1, '{rcn_pkg::Q_MAX, rcn_pkg::SW_ON, 1'b0}},
    '{12'd4095, 1'b1, '{rcn_pkg::Q_MAX, rcn_pkg::SW_ON, 1'b0}},
    '{12'd1000, 1'b1, '{rcn_pkg::Q_MIN, rcn_pkg::SW_OFF, 1'b0}},
    '{12'd0,    1'b1, '{rcn_pkg::Q_MIN, rcn_pkg::SW_OFF, 1'b0}},
    '{12'd1750, 1'b1, '{16'sd16384, rcn_pkg::SW_MID, 1'b0}},
    '{12'd1250, 1'b1, '{-16'sd16384, rcn_pkg::SW_OFF, 1'b0}},
    '{12'd2048, 1'b0, '{16'sd0, rcn_pkg::SW_OFF, 1'b0}},
    '{12'd1,    1'b0, '{16'sd0, rcn_pkg::SW_OFF, 1'b0}}
  };

  localparam corner_setting_t CORNERS [5] = '{
    // min above max, negative divisor
    '{12'd2000, 12'd1000, 12'd1500, 10'd0, 12'd0, 16'd24576, 16'd8192, 3'd0,
      12'd0, 12'd1500, 12'd4095},
    // reverse, dead zone, failsafe below min, threshold extremes
    '{12'd1000, 12'd2000, 12'd1500, 10'd100, 12'd900, 16'd32768, 16'd0, 3'd1,
      12'd0, 12'd1401, 12'd1601},
    // failsafe above max, thresholds above full travel, inverted tests
    '{12'd0, 12'd3000, 12'd1500, 10'd1023, 12'd3500, 16'd65535, 16'd40000, 3'd6,
      12'd4095, 12'd3500, 12'd476},
    // tiny span, saturation in both directions with reversal
    '{12'd1499, 12'd1501, 12'd1500, 10'd0, 12'd4095, 16'd0, 16'd65535, 3'd7,
      12'd1501, 12'd1499, 12'd1500},
    // full pulse range
    '{12'd0, 12'd4095, 12'd4095, 10'd1023, 12'd0, 16'd16384, 16'd16384, 3'd0,
      12'd0, 12'd4095, 12'd2048}
  };

  logic clk;
  logic rst = 1'b1;
  logic pulse_valid = 1'b0;
  logic pulse_stall;
  logic [11:0] raw_pulse = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [rcn_pkg::Q_BITS-1:0] normalized;
  logic [rcn_pkg::SW_POS_BITS-1:0] switch_position;
  logic failsafe_trip;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rcn_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [rcn_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  int min_us = rcn_pkg::RST_MIN_PULSE;
  int max_us = rcn_pkg::RST_MAX_PULSE;
  int center_us = rcn_pkg::RST_CENTER_PULSE;
  int dead_us = int'(rcn_pkg::RST_DEADBAND);
  int fs_us = rcn_pkg::RST_FAILSAFE_PULSE;
  int on_th = int'(rcn_pkg::RST_ON_THRESHOLD);
  int mid_th = int'(rcn_pkg::RST_MID_THRESHOLD);
  int pol_bits = int'(rcn_pkg::RST_POLARITY);

  chan_result_t awaited_channels [$];
  int fail_count = 0;
  int cycle_count = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int sender_idle_odds = 0;
  bit quiet_tail = 1'b0;

  rc_channel_normalizer i_dut (
    .clk             (clk),
    .rst             (rst),
    .pulse_valid     (pulse_valid),
    .pulse_stall     (pulse_stall),
    .raw_pulse       (raw_pulse),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .normalized      (normalized),
    .switch_position (switch_position),
    .failsafe_trip   (failsafe_trip),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint scaled(input longint num, input longint den);
    if (den <= 0) return 0;
    return (num * 32768) / den;
  endfunction

  function automatic chan_result_t predict_channel(input logic [11:0] raw);
    longint v;
    longint q;
    longint s;
    longint hi_edge;
    longint lo_edge;
    bit on_hit;
    bit mid_hit;
    int raw_i;
    chan_result_t r;
    raw_i = int'(raw);
    v = raw_i;
    if (v < min_us) v = min_us;
    if (v > max_us) v = max_us;
    hi_edge = center_us + dead_us;
    lo_edge = center_us - dead_us;
    if (v > hi_edge) q = scaled(v - hi_edge, max_us - hi_edge);
    else if (v < lo_edge) q = scaled(v - lo_edge, lo_edge - min_us);
    else q = 0;
    if (pol_bits[rcn_pkg::POL_REVERSE]) q = -q;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    s = q + 32768;
    on_hit = pol_bits[rcn_pkg::POL_INV_ON] ? (s < 2 * longint'(on_th)) :
                                             (s > 2 * longint'(on_th));
    mid_hit = pol_bits[rcn_pkg::POL_INV_MID] ? (s < 2 * longint'(mid_th)) :
                                               (s > 2 * longint'(mid_th));
    r.normalized = q[15:0];
    r.switch_position = on_hit ? rcn_pkg::SW_ON : (mid_hit ? rcn_pkg::SW_MID : rcn_pkg::SW_OFF);
    r.failsafe_trip = (fs_us != 0) &&
                      ((fs_us < min_us && raw_i < fs_us) || (fs_us > max_us && raw_i > fs_us));
    return r;
  endfunction

  function automatic logic [11:0] pick_pulse();
    int lo;
    int hi;
    int p;
    if ($urandom_range(0, 4) == 0) return 12'($urandom);
    lo = ((min_us < max_us) ? min_us : max_us) - 60;
    hi = ((min_us < max_us) ? max_us : min_us) + 60;
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    p = int'($urandom_range(hi, lo));
    if (fs_us != 0 && $urandom_range(0, 7) == 0) p = fs_us + int'($urandom_range(0, 4)) - 2;
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return p[11:0];
  endfunction

  task automatic write_reg(input logic [rcn_pkg::CFG_INDEX_BITS-1:0] idx, input int value);
    logic [15:0] keep;
    logic [15:0] word;
    case (idx)
      rcn_pkg::CFG_ON_THRESHOLD, rcn_pkg::CFG_MID_THRESHOLD: keep = 16'hFFFF;
      rcn_pkg::CFG_DEADBAND: keep = 16'h03FF;
      rcn_pkg::CFG_POLARITY_FLAGS: keep = 16'h0007;
      default: keep = 16'h0FFF;
    endcase
    word = (value[15:0] & keep) | (16'($urandom) & ~keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      rcn_pkg::CFG_MIN_PULSE: min_us = int'(word & keep);
      rcn_pkg::CFG_MAX_PULSE: max_us = int'(word & keep);
      rcn_pkg::CFG_CENTER_PULSE: center_us = int'(word & keep);
      rcn_pkg::CFG_DEADBAND: dead_us = int'(word & keep);
      rcn_pkg::CFG_FAILSAFE_PULSE: fs_us = int'(word & keep);
      rcn_pkg::CFG_ON_THRESHOLD: on_th = int'(word & keep);
      rcn_pkg::CFG_MID_THRESHOLD: mid_th = int'(word & keep);
      default: pol_bits = int'(word & keep);
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input int mn, input int mx, input int ctr, input int db,
                               input int fs, input int onth, input int midth, input int pl);
    write_reg(rcn_pkg::CFG_MIN_PULSE, mn);
    write_reg(rcn_pkg::CFG_MAX_PULSE, mx);
    write_reg(rcn_pkg::CFG_CENTER_PULSE, ctr);
    write_reg(rcn_pkg::CFG_DEADBAND, db);
    write_reg(rcn_pkg::CFG_FAILSAFE_PULSE, fs);
    write_reg(rcn_pkg::CFG_ON_THRESHOLD, onth);
    write_reg(rcn_pkg::CFG_MID_THRESHOLD, midth);
    write_reg(rcn_pkg::CFG_POLARITY_FLAGS, pl);
  endtask

  task automatic random_setting(input bit wild);
    int mn;
    int mx;
    int ctr;
    int db;
    int fs;
    int onth;
    int midth;
    if (wild) begin
      mn = $urandom_range(0, 4095);
      mx = $urandom_range(0, 4095);
      ctr = $urandom_range(0, 4095);
      db = $urandom_range(0, 1023);
      fs = $urandom_range(0, 4095);
      onth = $urandom_range(0, 65535);
      midth = $urandom_range(0, 65535);
    end else begin
      mn = $urandom_range(700, 1300);
      mx = $urandom_range(1700, 2300);
      ctr = $urandom_range(mn + 10, mx - 10);
      db = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 80);
      case ($urandom_range(0, 2))
        0: fs = 0;
        1: fs = $urandom_range(1, mn);
        default: fs = $urandom_range(mx, 4095);
      endcase
      onth = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(16384, 32768);
      midth = $urandom_range(0, 16384);
    end
    apply_setting(mn, mx, ctr, db, fs, onth, midth, $urandom_range(0, 7));
  endtask

  task automatic send_pulse(input logic [11:0] raw, input logic typed,
                            input chan_result_t typed_res);
    pulse_valid <= 1'b1;
    raw_pulse <= raw;
    @(posedge clk);
    while (pulse_stall) @(posedge clk);
    awaited_channels.push_back(typed ? typed_res : predict_channel(raw));
  endtask

  task automatic offer_gap();
    if (sender_idle_odds != 0 && !quiet_tail && $urandom_range(1, sender_idle_odds) == 1) begin
      pulse_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    pulse_valid <= 1'b0;
    while (awaited_channels.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES + 4) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (quiet_tail) begin
        result_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    chan_result_t got;
    chan_result_t want;
    if (!rst && result_valid && !result_stall) begin
      got = '{normalized, switch_position, failsafe_trip};
      if (awaited_channels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected item: normalized %0d switch %0d trip %0d",
                   got.normalized, got.switch_position, got.failsafe_trip);
      end else begin
        want = awaited_channels.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: q exp %0d got %0d, sw exp %0d got %0d, trip exp %0d got %0d",
                     want.normalized, got.normalized, want.switch_position,
                     got.switch_position, want.failsafe_trip, got.failsafe_trip);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("** rc_channel_normalizer: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (RESET_ROWS[r])
      send_pulse(RESET_ROWS[r].raw, RESET_ROWS[r].typed, RESET_ROWS[r].res);
    wait_idle();

    foreach (CORNERS[k]) begin
      apply_setting(CORNERS[k].mn, CORNERS[k].mx, CORNERS[k].ctr, CORNERS[k].db,
                    CORNERS[k].fs, CORNERS[k].onth, CORNERS[k].midth, CORNERS[k].pl);
      send_pulse(CORNERS[k].p0, 1'b0, '0);
      send_pulse(CORNERS[k].p1, 1'b0, '0);
      send_pulse(CORNERS[k].p2, 1'b0, '0);
      wait_idle();
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setting(ph % 3 == 2);
      sender_idle_odds = (ph % 2 == 0) ? 3 : 0;
      quiet_tail = (ph == RANDOM_PHASES - 1);
      if (ph == 3) begin
        sender_idle_odds = 0;
        holds_asked++;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == PHASE_ITEMS / 2) wait_idle();
        offer_gap();
        send_pulse(pick_pulse(), 1'b0, '0);
      end
      wait_idle();
    end

    if (fail_count == 0 && awaited_channels.size() == 0)
      $display("** rc_channel_normalizer: PASSED **");
    else
      $display("** rc_channel_normalizer: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rcn_pkg.sv
hdl/rcn_front.sv
hdl/rcn_div_stage.sv
hdl/rcn_back.sv
hdl/rc_channel_normalizer.sv
bench/testbench.sv
